FILE: sv/http_header_line_parser_unit_assert.svh
// assertion macros shared by the parser modules
`ifndef HTTP_HEADER_LINE_PARSER_UNIT_ASSERT_SVH
`define HTTP_HEADER_LINE_PARSER_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define HHLP_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("hhlp assertion failed");

// property that must hold in the cycle after the trigger
`define HHLP_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("hhlp assertion failed");

`endif

FILE: sv/hhlp_pkg.sv
`default_nettype none

package hhlp_pkg;

	localparam int MAX_HEADER_BYTES = 65535;
	localparam int LIMIT_INT = (MAX_HEADER_BYTES > 65535) ? 65535 : MAX_HEADER_BYTES;
	localparam logic [15:0] BYTE_LIMIT = 16'(LIMIT_INT);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] ST_HEADER = 2'd0;
	localparam logic [1:0] ST_END = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] name_length;
		logic        value_present;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [15:0] consumed;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic    valid_a;
		logic    valid_b;
		result_t res_a;
		result_t res_b;
	} push_t;

endpackage

`default_nettype wire

FILE: sv/hhlp_core.sv
`default_nettype none

`include "http_header_line_parser_unit_assert.svh"

module hhlp_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     data_byte,
	input  wire logic           buffer_end,
	input  wire logic           room,
	output hhlp_pkg::push_t     push
);

	typedef enum logic [2:0] {
		PH_INIT,
		PH_NAME,
		PH_NAME_WS,
		PH_VAL_LEAD,
		PH_VALUE,
		PH_CR,
		PH_FOLD,
		PH_DROP
	} phase_t;

	typedef struct packed {
		logic [15:0] position;
		logic [15:0] name_end;
		logic [15:0] value_start;
		logic [15:0] last_visible;
		logic [15:0] value_end;
		logic        value_seen;
		logic        name_seen;
	} hdr_state_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire;

	phase_t     phase_q, phase_d, ph;
	hdr_state_t st_q, st_d, s;
	logic       done, bad;
	logic [15:0] idx;
	hhlp_pkg::result_t res_a, res_b;
	logic       va, vb;

	function automatic logic is_blank(logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09);
	endfunction

	function automatic logic is_visible(logic [7:0] c);
		return (c >= 8'h21) && (c <= 8'h7e);
	endfunction

	function automatic logic is_token(logic [7:0] c);
		logic t;
		case (c) inside
			[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]: t = 1'b1;
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
			8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: t = 1'b1;
			default: t = 1'b0;
		endcase
		return t;
	endfunction

	function automatic hhlp_pkg::result_t hdr_result(hdr_state_t h, logic [15:0] cons);
		hhlp_pkg::result_t r;
		r = '0;
		r.consumed = cons;
		if (!h.name_seen) begin
			r.status = hhlp_pkg::ST_END;
		end else begin
			r.status = hhlp_pkg::ST_HEADER;
			r.name_length = h.name_end;
			if (h.value_seen) begin
				r.value_present = 1'b1;
				r.value_offset = h.value_start;
				r.value_length = h.value_end - h.value_start;
			end
		end
		return r;
	endfunction

	function automatic hhlp_pkg::result_t bad_result(logic [15:0] cons);
		hhlp_pkg::result_t r;
		r = '0;
		r.status = hhlp_pkg::ST_MALFORMED;
		r.consumed = cons;
		return r;
	endfunction

	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_comb begin
		phase_d = phase_q;
		st_d = st_q;
		ph = phase_q;
		s = st_q;
		res_a = '0;
		res_b = '0;
		va = 1'b0;
		vb = 1'b0;
		done = 1'b0;
		bad = 1'b0;
		idx = '0;
		if (fire) begin
			if (phase_q == PH_DROP) begin
				if (last_s1) begin
					phase_d = PH_INIT;
				end
			end else begin
				if (ph == PH_FOLD && !is_blank(byte_s1)) begin
					va = 1'b1;
					res_a = hdr_result(s, s.position);
					s = '0;
					ph = PH_INIT;
				end
				if (s.position >= hhlp_pkg::BYTE_LIMIT) begin
					vb = 1'b1;
					res_b = bad_result(s.position);
					s = '0;
					ph = last_s1 ? PH_INIT : PH_DROP;
				end else begin
					idx = s.position;
					s.position = s.position + 16'd1;
					unique case (ph)
						PH_INIT: begin
							if (byte_s1 == 8'h0d) ph = PH_CR;
							else if (is_blank(byte_s1)) bad = 1'b1;
							else begin
								s.name_seen = 1'b1;
								ph = PH_NAME;
							end
						end
						PH_NAME: begin
							if (is_token(byte_s1)) begin
							end else if (byte_s1 == 8'h3a) begin
								s.name_end = idx;
								ph = PH_VAL_LEAD;
							end else if (is_blank(byte_s1)) begin
								s.name_end = idx;
								ph = PH_NAME_WS;
							end else bad = 1'b1;
						end
						PH_NAME_WS: begin
							if (is_blank(byte_s1)) begin
							end else if (byte_s1 == 8'h3a) ph = PH_VAL_LEAD;
							else bad = 1'b1;
						end
						PH_VAL_LEAD: begin
							if (is_blank(byte_s1)) begin
							end else if (byte_s1 == 8'h0d) ph = PH_CR;
							else if (is_visible(byte_s1)) begin
								s.value_seen = 1'b1;
								s.value_start = idx;
								s.last_visible = idx;
								ph = PH_VALUE;
							end else bad = 1'b1;
						end
						PH_VALUE: begin
							if (is_blank(byte_s1)) begin
							end else if (byte_s1 == 8'h0d) begin
								if (s.value_seen) s.value_end = s.last_visible + 16'd1;
								ph = PH_CR;
							end else if (is_visible(byte_s1)) begin
								if (!s.value_seen) begin
									s.value_seen = 1'b1;
									s.value_start = idx;
								end
								s.last_visible = idx;
							end
						end
						PH_CR: begin
							if (byte_s1 == 8'h0a) begin
								if (last_s1) done = 1'b1;
								else ph = PH_FOLD;
							end else bad = 1'b1;
						end
						default: begin
							// fold followed by a blank
							ph = PH_VALUE;
						end
					endcase
					if (done) begin
						vb = 1'b1;
						res_b = hdr_result(s, s.position);
						s = '0;
						ph = PH_INIT;
					end else if (bad || last_s1) begin
						vb = 1'b1;
						res_b = bad_result(s.position);
						s = '0;
						ph = last_s1 ? PH_INIT : PH_DROP;
					end
				end
				phase_d = ph;
				st_d = s;
			end
		end
		res_a.last_of_run = !vb;
		res_b.last_of_run = 1'b1;
	end

	assign push = {va, vb, res_a, res_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q <= PH_INIT;
			st_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			phase_q <= phase_d;
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= buffer_end;
		end
	end

	`HHLP_ASSERT_ALWAYS(a_pos_limit, st_q.position <= hhlp_pkg::BYTE_LIMIT)
	`HHLP_ASSERT_ALWAYS(a_init_clear, (phase_q != PH_INIT) || (st_q.position == 16'd0))
	`HHLP_ASSERT_ALWAYS(a_drop_silent, !(fire && phase_q == PH_DROP) || (!va && !vb))
	`HHLP_ASSERT_ALWAYS(a_pair_order, !(va && vb) || (res_a.status != hhlp_pkg::ST_MALFORMED))

endmodule

`default_nettype wire

FILE: sv/hhlp_result_fifo.sv
`default_nettype none

`include "http_header_line_parser_unit_assert.svh"

module hhlp_result_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hhlp_pkg::push_t   push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hhlp_pkg::result_t      head
);

	hhlp_pkg::result_t entry_q [hhlp_pkg::FIFO_DEPTH];
	logic [hhlp_pkg::PTR_W-1:0] wr_q, rd_q;
	logic [hhlp_pkg::CNT_W-1:0] count_q;
	logic [hhlp_pkg::CNT_W-1:0] n_push;
	logic pop;

	assign room = count_q <= hhlp_pkg::CNT_W'(hhlp_pkg::FIFO_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign pop = out_valid && out_ready;
	assign head = entry_q[rd_q];
	assign n_push = hhlp_pkg::CNT_W'(push.valid_a) + hhlp_pkg::CNT_W'(push.valid_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + hhlp_pkg::PTR_W'(n_push);
			if (pop) begin
				rd_q <= rd_q + hhlp_pkg::PTR_W'(1);
			end
			count_q <= count_q + n_push - hhlp_pkg::CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid_a && push.valid_b) begin
			entry_q[wr_q] <= push.res_a;
			entry_q[wr_q + hhlp_pkg::PTR_W'(1)] <= push.res_b;
		end else if (push.valid_a) begin
			entry_q[wr_q] <= push.res_a;
		end else if (push.valid_b) begin
			entry_q[wr_q] <= push.res_b;
		end
	end

	`HHLP_ASSERT_ALWAYS(a_no_overflow,
		(32'(count_q) + 32'(n_push)) <= hhlp_pkg::FIFO_DEPTH)
	`HHLP_ASSERT_ALWAYS(a_count_range, count_q <= hhlp_pkg::CNT_W'(hhlp_pkg::FIFO_DEPTH))
	`HHLP_ASSERT_NEXT(a_drain, pop && n_push == '0 && count_q == hhlp_pkg::CNT_W'(1),
		count_q == '0)

endmodule

`default_nettype wire

FILE: sv/http_header_line_parser_unit.sv
// channel   signals                        payload
// in        in_valid / in_ready            data_byte, buffer_end
// out       out_valid / out_ready          status, name_length, value_present,
//                                          value_offset, value_length, consumed,
//                                          last_of_run
//
// one byte enters per cycle while in_ready is high; a byte is registered and is parsed
// from that register once at least two of the four queue entries are free; a byte
// gives zero, one or two results, which leave one per cycle while out_ready is high
// arst_n clears the parse state to the start of a header and empties the queue
// a stalled output fills the queue and then holds in_ready low
`default_nettype none

module http_header_line_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        buffer_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      name_length,
	output logic             value_present,
	output logic [15:0]      value_offset,
	output logic [15:0]      value_length,
	output logic [15:0]      consumed,
	output logic             last_of_run
);

	hhlp_pkg::push_t   push;
	hhlp_pkg::result_t head;
	logic              room;

	hhlp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.room       (room),
		.push       (push)
	);

	hhlp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign status = head.status;
	assign name_length = head.name_length;
	assign value_present = head.value_present;
	assign value_offset = head.value_offset;
	assign value_length = head.value_length;
	assign consumed = head.consumed;
	assign last_of_run = head.last_of_run;

endmodule

`default_nettype wire
